### rtl/core/asl_pkg.sv
// ----------------------------------------------------------------------------
// asl_pkg
// Types, token codes, character codes and keyword tables shared by the
// assembly source lexer front end, token queue and token issue stage.
// ----------------------------------------------------------------------------
package asl_pkg;

   // Token kinds
   localparam logic [3:0] TK_EOF       = 4'd0;
   localparam logic [3:0] TK_INVALID   = 4'd1;
   localparam logic [3:0] TK_OPCODE    = 4'd2;
   localparam logic [3:0] TK_DIRECTIVE = 4'd3;
   localparam logic [3:0] TK_IDENT     = 4'd4;
   localparam logic [3:0] TK_NUMBER    = 4'd5;
   localparam logic [3:0] TK_COMMA     = 4'd6;
   localparam logic [3:0] TK_NEWLINE   = 4'd7;
   localparam logic [3:0] TK_COMMENT   = 4'd8;

   // Input item kinds
   localparam logic ITEM_BYTE = 1'b0;
   localparam logic ITEM_END  = 1'b1;

   // Character codes
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UF    = 8'h46;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LF_HEX = 8'h66;
   localparam logic [7:0] CH_LZ    = 8'h7A;
   localparam logic [7:0] CASE_GAP = 8'h20;

   // Keyword buffer geometry
   localparam int KEYWORD_CHARS = 8;
   localparam int KW_IDX_BITS   = 3;
   localparam int KW_BITS       = 8 * KEYWORD_CHARS;
   localparam logic [3:0] WLEN_LONG = 4'hF;

   // Keyword tables, text right-justified (first char is the highest byte used)
   localparam int OP_COUNT  = 13;
   localparam int DIR_COUNT = 3;

   localparam logic [KW_BITS-1:0] OP_TEXT [OP_COUNT] = '{
      KW_BITS'("LOAD"), KW_BITS'("STORE"), KW_BITS'("ADD"), KW_BITS'("SUBT"),
      KW_BITS'("INPUT"), KW_BITS'("OUTPUT"), KW_BITS'("HALT"),
      KW_BITS'("SKIPCOND"), KW_BITS'("JUMP"), KW_BITS'("JNS"),
      KW_BITS'("CLEAR"), KW_BITS'("ADDI"), KW_BITS'("JUMPI")
   };
   localparam logic [3:0] OP_LEN [OP_COUNT] = '{
      4'd4, 4'd5, 4'd3, 4'd4, 4'd5, 4'd6, 4'd4, 4'd8, 4'd4, 4'd3, 4'd5, 4'd4, 4'd5
   };
   localparam logic [3:0] OP_VAL [OP_COUNT] = '{
      4'h1, 4'h2, 4'h3, 4'h4, 4'h5, 4'h6, 4'h7, 4'h8, 4'h9, 4'h0, 4'hA, 4'hB, 4'hC
   };

   localparam logic [KW_BITS-1:0] DIR_TEXT [DIR_COUNT] = '{
      KW_BITS'("ORG"), KW_BITS'("DEC"), KW_BITS'("HEX")
   };
   localparam logic [3:0] DIR_LEN [DIR_COUNT] = '{4'd3, 4'd3, 4'd3};
   localparam logic [3:0] DIR_VAL [DIR_COUNT] = '{4'd1, 4'd2, 4'd3};

   // Token queue geometry
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = 2;
   localparam int QUEUE_CNT_BITS = 3;

   // Keyword lookup result
   typedef struct packed {
      logic       is_op;
      logic       is_dir;
      logic [3:0] value;
   } kw_type;

   // Tokens caused by one input item: an optional word or comment token,
   // then an optional newline, comma or eof token, all on one line
   typedef struct packed {
      logic        head_valid;
      logic [3:0]  head_kind;
      logic [3:0]  head_value;
      logic [15:0] head_offset;
      logic [15:0] head_length;
      logic        tail_valid;
      logic [3:0]  tail_kind;
      logic [15:0] tail_offset;
      logic [15:0] line;
      logic [15:0] line_start;
   } job_type;

   typedef struct packed {
      logic    push;
      job_type job;
   } push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic is_hex(input logic [7:0] b);
      return (b >= CH_0 && b <= CH_9) || (b >= CH_LA && b <= CH_LF_HEX) ||
             (b >= CH_UA && b <= CH_UF);
   endfunction

   function automatic logic is_lead_digit(input logic [7:0] b);
      return (b == CH_MINUS) || (b >= CH_0 && b <= CH_9);
   endfunction

   function automatic logic text_eq(input logic [KW_BITS-1:0] kbuf,
                                    input logic [3:0] wlen,
                                    input logic [KW_BITS-1:0] text,
                                    input logic [3:0] tlen);
      logic eq;
      eq = (wlen == tlen);
      for (int i = 0; i < KEYWORD_CHARS; i++) begin
         if (i < int'(tlen)) begin
            if (kbuf[8*i +: 8] != text[8*(int'(tlen) - 1 - i) +: 8]) begin
               eq = 1'b0;
            end
         end
      end
      return eq;
   endfunction

   function automatic kw_type classify(input logic [KW_BITS-1:0] kbuf,
                                       input logic [3:0] wlen);
      kw_type r;
      r = '0;
      for (int k = 0; k < DIR_COUNT; k++) begin
         if (text_eq(kbuf, wlen, DIR_TEXT[k], DIR_LEN[k])) begin
            r.is_dir = 1'b1;
            r.value  = DIR_VAL[k];
         end
      end
      // opcodes take priority over directives
      for (int k = 0; k < OP_COUNT; k++) begin
         if (text_eq(kbuf, wlen, OP_TEXT[k], OP_LEN[k])) begin
            r.is_op  = 1'b1;
            r.value  = OP_VAL[k];
         end
      end
      return r;
   endfunction

endpackage

### rtl/core/asl_front.sv
// ----------------------------------------------------------------------------
// asl_front
// Accepts source bytes and end of input, tracks word, comment and line
// state, classifies finished words and pushes the tokens of each item.
// ----------------------------------------------------------------------------
module asl_front import asl_pkg::*; #(
   parameter int POSITION_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_kind,
   input  logic [7:0]       req_source_byte,
   output push_type         push_out,
   input  queue_status_type q_status
);

   localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [POSITION_BITS-1:0] line_ff, line_in;
   logic [POSITION_BITS-1:0] lstart_ff, lstart_in;
   logic                     in_word_ff, in_word_in;
   logic [POSITION_BITS-1:0] wstart_ff, wstart_in;
   logic [POSITION_BITS-1:0] wlen_ff, wlen_in;
   logic                     num_ok_ff, num_ok_in;
   logic                     in_cmt_ff, in_cmt_in;
   logic [POSITION_BITS-1:0] cstart_ff, cstart_in;
   logic                     halted_ff, halted_in;
   logic [7:0]               kbuf_ff [KEYWORD_CHARS];

   logic                     accept;
   logic [KW_BITS-1:0]       kbuf_flat;
   logic [3:0]               wlen_code;
   kw_type                   kw;
   logic [3:0]               word_kind;
   logic                     word_bad;
   logic                     is_sep;
   logic [7:0]               up_byte;
   logic [POSITION_BITS-1:0] wr_len;
   logic                     kbuf_we;
   logic [POSITION_BITS-1:0] cmt_len;
   job_type                  job;

   function automatic logic [POSITION_BITS-1:0] sat_inc(
      input logic [POSITION_BITS-1:0] x);
      return (x != POS_MAX) ? x + POSITION_BITS'(1) : x;
   endfunction

   function automatic logic [15:0] clip16(input logic [POSITION_BITS-1:0] x);
      return (x > POSITION_BITS'(16'hFFFF)) ? 16'hFFFF : 16'(x);
   endfunction

   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;

   // Classify the open word from the keyword buffer
   always_comb begin
      for (int i = 0; i < KEYWORD_CHARS; i++) begin
         kbuf_flat[8*i +: 8] = kbuf_ff[i];
      end
   end

   assign wlen_code = (wlen_ff <= POSITION_BITS'(KEYWORD_CHARS)) ? wlen_ff[3:0] : WLEN_LONG;
   assign kw        = classify(kbuf_flat, wlen_code);

   always_comb begin
      word_bad = 1'b0;
      if (kw.is_op) begin
         word_kind = TK_OPCODE;
      end else if (kw.is_dir) begin
         word_kind = TK_DIRECTIVE;
      end else if (is_lead_digit(kbuf_ff[0])) begin
         word_kind = num_ok_ff ? TK_NUMBER : TK_INVALID;
         word_bad  = !num_ok_ff;
      end else begin
         word_kind = TK_IDENT;
      end
   end

   assign is_sep = (req_source_byte == CH_SPACE) || (req_source_byte == CH_TAB) ||
                   (req_source_byte == CH_CR) || (req_source_byte == CH_LF) ||
                   (req_source_byte == CH_COMMA) || (req_source_byte == CH_SLASH);
   assign up_byte = (req_source_byte >= CH_LA && req_source_byte <= CH_LZ) ?
                    req_source_byte - CASE_GAP : req_source_byte;
   assign wr_len  = in_word_ff ? wlen_ff : '0;
   assign cmt_len = sat_inc(pos_ff - cstart_ff);

   // Step the lexer state and build the job for this item
   always_comb begin
      pos_in     = pos_ff;
      line_in    = line_ff;
      lstart_in  = lstart_ff;
      in_word_in = in_word_ff;
      wstart_in  = wstart_ff;
      wlen_in    = wlen_ff;
      num_ok_in  = num_ok_ff;
      in_cmt_in  = in_cmt_ff;
      cstart_in  = cstart_ff;
      halted_in  = halted_ff;
      kbuf_we    = 1'b0;

      job             = '0;
      job.line        = clip16(line_ff);
      job.line_start  = clip16(lstart_ff);
      job.tail_offset = clip16(pos_ff);

      if (in_cmt_ff) begin
         job.head_kind   = TK_COMMENT;
         job.head_offset = clip16(cstart_ff);
         job.head_length = clip16(cmt_len);
      end else begin
         job.head_kind   = word_kind;
         job.head_value  = (kw.is_op || kw.is_dir) ? kw.value : 4'd0;
         job.head_offset = clip16(wstart_ff);
         job.head_length = clip16(wlen_ff);
      end

      if (halted_ff) begin
         // drop everything until reset
      end else if (req_kind == ITEM_END) begin
         halted_in  = 1'b1;
         in_cmt_in  = 1'b0;
         in_word_in = 1'b0;
         job.head_valid = in_cmt_ff || in_word_ff;
         if (!(in_word_ff && word_bad)) begin
            job.tail_valid = 1'b1;
            job.tail_kind  = TK_EOF;
         end
      end else if (in_cmt_ff) begin
         if (req_source_byte == CH_LF) begin
            job.head_valid = 1'b1;
            job.tail_valid = 1'b1;
            job.tail_kind  = TK_NEWLINE;
            in_cmt_in      = 1'b0;
            line_in        = sat_inc(line_ff);
            lstart_in      = sat_inc(pos_ff);
         end
         pos_in = sat_inc(pos_ff);
      end else if (is_sep) begin
         if (in_word_ff) begin
            job.head_valid = 1'b1;
            in_word_in     = 1'b0;
         end
         if (in_word_ff && word_bad) begin
            halted_in = 1'b1;
         end else begin
            if (req_source_byte == CH_LF) begin
               job.tail_valid = 1'b1;
               job.tail_kind  = TK_NEWLINE;
               line_in        = sat_inc(line_ff);
               lstart_in      = sat_inc(pos_ff);
            end else if (req_source_byte == CH_COMMA) begin
               job.tail_valid = 1'b1;
               job.tail_kind  = TK_COMMA;
            end else if (req_source_byte == CH_SLASH) begin
               in_cmt_in = 1'b1;
               cstart_in = pos_ff;
            end
            pos_in = sat_inc(pos_ff);
         end
      end else begin
         if (!in_word_ff) begin
            in_word_in = 1'b1;
            wstart_in  = pos_ff;
            num_ok_in  = is_lead_digit(req_source_byte);
         end else begin
            num_ok_in  = num_ok_ff && is_hex(req_source_byte);
         end
         kbuf_we = (wr_len < POSITION_BITS'(KEYWORD_CHARS));
         wlen_in = sat_inc(wr_len);
         pos_in  = sat_inc(pos_ff);
      end
   end

   assign push_out.push = accept && (job.head_valid || job.tail_valid);
   assign push_out.job  = job;

   // Hold lexer state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         line_ff    <= POSITION_BITS'(1);
         lstart_ff  <= '0;
         in_word_ff <= 1'b0;
         wstart_ff  <= '0;
         wlen_ff    <= '0;
         num_ok_ff  <= 1'b0;
         in_cmt_ff  <= 1'b0;
         cstart_ff  <= '0;
         halted_ff  <= 1'b0;
      end else if (accept) begin
         pos_ff     <= pos_in;
         line_ff    <= line_in;
         lstart_ff  <= lstart_in;
         in_word_ff <= in_word_in;
         wstart_ff  <= wstart_in;
         wlen_ff    <= wlen_in;
         num_ok_ff  <= num_ok_in;
         in_cmt_ff  <= in_cmt_in;
         cstart_ff  <= cstart_in;
         halted_ff  <= halted_in;
      end
   end

   // Write the upper-cased byte into the keyword buffer
   always_ff @(posedge clock) begin
      if (accept && kbuf_we) begin
         kbuf_ff[wr_len[KW_IDX_BITS-1:0]] <= up_byte;
      end
   end

endmodule

### rtl/core/asl_queue.sv
// ----------------------------------------------------------------------------
// asl_queue
// Short first-in first-out queue of token jobs between the front end and
// the token issue stage.
// ----------------------------------------------------------------------------
module asl_queue import asl_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  push_type         push_in,
   input  logic             pop,
   output queue_status_type q_status,
   output job_type          head_job
);

   job_type                   slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic                      do_push;
   logic                      do_pop;

   assign q_status.full  = (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign do_push        = push_in.push && !q_status.full;
   assign do_pop         = pop && !q_status.empty;
   assign head_job       = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QUEUE_CNT_BITS'(1);
      end
   end

   // Advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_PTR_BITS'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_PTR_BITS'(1);
         end
      end
   end

   // Store the pushed job
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_in.job;
      end
   end

endmodule

### rtl/core/asl_back.sv
// ----------------------------------------------------------------------------
// asl_back
// Token issue stage: takes jobs from the queue and hands their tokens to
// the result channel one transfer at a time through an output register.
// ----------------------------------------------------------------------------
module asl_back import asl_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_status,
   input  job_type          head_job,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [3:0]       rsp_token_kind,
   output logic [15:0]      rsp_token_offset,
   output logic [15:0]      rsp_token_length,
   output logic [15:0]      rsp_token_line,
   output logic [15:0]      rsp_token_line_start,
   output logic [3:0]       rsp_token_value,
   output logic             rsp_last_of_run
);

   logic        valid_ff;
   logic        tail_phase_ff, tail_phase_in;
   logic [3:0]  kind_ff, kind_in;
   logic [15:0] offset_ff, offset_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] line_ff;
   logic [15:0] lstart_ff;
   logic [3:0]  value_ff, value_in;
   logic        last_ff, last_in;
   logic        load;
   logic        issue;
   logic        use_head;

   assign load     = !valid_ff || !rsp_stall;
   assign issue    = load && !q_status.empty;
   assign use_head = head_job.head_valid && !tail_phase_ff;

   // Pick the next token of the job at the queue head
   always_comb begin
      tail_phase_in = tail_phase_ff;
      pop           = 1'b0;
      if (use_head) begin
         kind_in   = head_job.head_kind;
         offset_in = head_job.head_offset;
         length_in = head_job.head_length;
         value_in  = head_job.head_value;
         last_in   = !head_job.tail_valid;
      end else begin
         kind_in   = head_job.tail_kind;
         offset_in = head_job.tail_offset;
         length_in = (head_job.tail_kind == TK_EOF) ? 16'd0 : 16'd1;
         value_in  = 4'd0;
         last_in   = 1'b1;
      end
      if (issue) begin
         if (use_head && head_job.tail_valid) begin
            tail_phase_in = 1'b1;
         end else begin
            tail_phase_in = 1'b0;
            pop           = 1'b1;
         end
      end
   end

   // Hold the output register until the transfer completes
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         tail_phase_ff <= 1'b0;
      end else begin
         tail_phase_ff <= tail_phase_in;
         if (load) begin
            valid_ff <= !q_status.empty;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         kind_ff   <= kind_in;
         offset_ff <= offset_in;
         length_ff <= length_in;
         line_ff   <= head_job.line;
         lstart_ff <= head_job.line_start;
         value_ff  <= value_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_valid            = valid_ff;
   assign rsp_token_kind       = kind_ff;
   assign rsp_token_offset     = offset_ff;
   assign rsp_token_length     = length_ff;
   assign rsp_token_line       = line_ff;
   assign rsp_token_line_start = lstart_ff;
   assign rsp_token_value      = value_ff;
   assign rsp_last_of_run      = last_ff;

endmodule

### rtl/core/assembly_source_lexer.sv
// ----------------------------------------------------------------------------
// assembly_source_lexer
// Lexes assembly source, one byte per transfer, into opcode, directive,
// identifier, number, comma, newline, comment, invalid and eof tokens.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  req      in         req_valid/req_stall  kind, source_byte
//  rsp      out        rsp_valid/rsp_stall  token_kind .. last_of_run
//
//  One byte is taken per cycle while the four-entry token queue has room.
//  Tokens leave rsp one at a time, at most two per item, so one item per
//  cycle is sustained while items average one token or less and rsp does
//  not stall. An item's first token passes the queue and the output register
//  before it is valid on rsp. Reset clears lexer and queue control state;
//  no clearing pass. A stall on rsp fills the queue, then raises req_stall.
// ----------------------------------------------------------------------------
module assembly_source_lexer import asl_pkg::*; #(
   parameter int POSITION_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [7:0]  req_source_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_token_kind,
   output logic [15:0] rsp_token_offset,
   output logic [15:0] rsp_token_length,
   output logic [15:0] rsp_token_line,
   output logic [15:0] rsp_token_line_start,
   output logic [3:0]  rsp_token_value,
   output logic        rsp_last_of_run
);

   push_type         push;
   queue_status_type q_status;
   job_type          head_job;
   logic             pop;

   asl_front #(
      .POSITION_BITS(POSITION_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_source_byte (req_source_byte),
      .push_out        (push),
      .q_status        (q_status)
   );

   asl_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push_in  (push),
      .pop      (pop),
      .q_status (q_status),
      .head_job (head_job)
   );

   asl_back u_back (
      .clock                (clock),
      .reset                (reset),
      .q_status             (q_status),
      .head_job             (head_job),
      .pop                  (pop),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_token_kind       (rsp_token_kind),
      .rsp_token_offset     (rsp_token_offset),
      .rsp_token_length     (rsp_token_length),
      .rsp_token_line       (rsp_token_line),
      .rsp_token_line_start (rsp_token_line_start),
      .rsp_token_value      (rsp_token_value),
      .rsp_last_of_run      (rsp_last_of_run)
   );

endmodule

### rtl/core/asl_checker.sv
// ----------------------------------------------------------------------------
// asl_checker
// Port-level checks on the lexer's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module asl_checker import asl_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [3:0]  rsp_token_kind,
   input logic [15:0] rsp_token_offset,
   input logic [15:0] rsp_token_length,
   input logic        rsp_last_of_run
);

   // no result right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_token_kind) &&
      $stable(rsp_token_offset) && $stable(rsp_token_length) &&
      $stable(rsp_last_of_run))
      else $error("stalled result changed");

   // eof closes its run and has no length
   a_eof_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind == TK_EOF |-> rsp_last_of_run &&
      rsp_token_length == 16'd0)
      else $error("eof token malformed");

   // comma and newline are single-byte tokens ending their run
   a_punct: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_token_kind == TK_COMMA || rsp_token_kind == TK_NEWLINE) |->
      rsp_token_length == 16'd1 && rsp_last_of_run)
      else $error("punctuation token malformed");

   // a comment token never has length 0
   a_comment_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind == TK_COMMENT |-> rsp_token_length != 16'd0)
      else $error("comment token has zero length");

endmodule

bind assembly_source_lexer asl_checker u_asl_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_token_kind   (rsp_token_kind),
   .rsp_token_offset (rsp_token_offset),
   .rsp_token_length (rsp_token_length),
   .rsp_last_of_run  (rsp_last_of_run)
);
